### src/lbr_pkg.sv
package lbr_pkg;

   // Operation codes
   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_APPEND = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_PEEK   = 3'd3;
   localparam logic [2:0] OP_UNARY  = 3'd4;
   localparam logic [2:0] OP_SKIP   = 3'd5;
   localparam logic [2:0] OP_ALIGN  = 3'd6;

   // Field limits and fetch window
   localparam int READ_MAX_BITS = 32;
   localparam int PEEK_MAX_BITS = 24;
   localparam int FETCH_BYTES   = 5;
   localparam int FETCH_CW      = 3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic clear;
      logic append;
      logic advance;
      logic align;
      logic set_ok;
      logic ok_value;
      logic gather_init;
      logic gather_step;
      logic gather_end;
      logic unary_init;
      logic unary_load;
      logic unary_bit;
      logic unary_end;
      logic publish;
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [2:0] op;
      logic       full;
      logic       read_fits;
      logic       peek_fits;
      logic       skip_fits;
      logic       gather_last;
      logic       at_max;
      logic       empty;
      logic       byte_valid;
      logic       bit_hit;
   } ctl_sts_type;

endpackage

### src/lbr_datapath.sv
module lbr_datapath #(
   parameter int PACKET_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lbr_pkg::ctl_cmd_type cmd,
   output lbr_pkg::ctl_sts_type sts,
   input  logic [2:0]           req_operation,
   input  logic [7:0]           req_byte_value,
   input  logic [15:0]          req_bit_count,
   input  logic                 req_stop_bit,
   input  logic [15:0]          req_max_value,
   output logic                 rsp_ok,
   output logic [31:0]          rsp_value,
   output logic [15:0]          rsp_bits_consumed,
   output logic [15:0]          rsp_bits_remaining
);

   localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
   localparam int LW = $clog2(PACKET_BYTES + 1);
   localparam int PW = LW + 3;
   localparam int CW = (PW > 16) ? PW : 16;
   localparam logic [LW-1:0] FULL_LEN = LW'(PACKET_BYTES);

   // Byte store
   logic [7:0] mem [PACKET_BYTES];

   // Captured request
   logic [2:0]  op_ff;
   logic [7:0]  byte_ff;
   logic [15:0] cnt_ff;
   logic        stop_ff;
   logic [15:0] max_ff;

   // Packet state
   logic [LW-1:0] len_ff, len_in;
   logic [PW-1:0] pos_ff, pos_in;

   // Fetch and unary working registers
   logic [7:0]                    rd_data_ff;
   logic                          rd_ok_ff;
   logic [lbr_pkg::FETCH_CW-1:0]  k_ff;
   logic [8*lbr_pkg::FETCH_BYTES-1:0] buf_ff;
   logic [7:0]                    cur_byte_ff;
   logic                          byte_valid_ff;
   logic [15:0]                   ucnt_ff;

   // Result registers
   logic        ok_ff;
   logic [31:0] val_ff;
   logic [15:0] cons_ff;
   logic [15:0] rem_ff;

   // Derived values
   logic [PW-1:0] total;
   logic [PW-1:0] left;
   logic [LW-1:0] first;
   logic [LW:0]   idx;
   logic          in_range;
   logic [AW-1:0] raddr;
   logic [PW:0]   up;
   logic [PW:0]   up_al;
   logic [8*lbr_pkg::FETCH_BYTES-1:0] shifted;
   logic [32:0]   mask;
   logic [31:0]   field;
   logic          bit_hit;

   assign total    = {len_ff, 3'b000};
   assign left     = total - pos_ff;
   assign first    = pos_ff[PW-1:3];
   assign idx      = {1'b0, first} + (cmd.gather_step ? (LW+1)'(k_ff) : '0);
   assign in_range = idx < {1'b0, len_ff};
   assign raddr    = in_range ? idx[AW-1:0] : '0;
   assign up       = {1'b0, pos_ff} + (PW+1)'(7);
   assign up_al    = {up[PW:3], 3'b000};
   assign shifted  = buf_ff >> pos_ff[2:0];
   assign mask     = (33'd1 << cnt_ff[5:0]) - 33'd1;
   assign field    = shifted[31:0] & mask[31:0];
   assign bit_hit  = cur_byte_ff[pos_ff[2:0]] == stop_ff;

   // Status toward the controller
   always_comb begin
      sts             = '0;
      sts.op          = op_ff;
      sts.full        = len_ff == FULL_LEN;
      sts.skip_fits   = CW'(left) >= CW'(cnt_ff);
      sts.read_fits   = sts.skip_fits && (cnt_ff <= 16'(lbr_pkg::READ_MAX_BITS));
      sts.peek_fits   = sts.skip_fits && (cnt_ff <= 16'(lbr_pkg::PEEK_MAX_BITS));
      sts.gather_last = k_ff == lbr_pkg::FETCH_CW'(lbr_pkg::FETCH_BYTES);
      sts.at_max      = ucnt_ff >= max_ff;
      sts.empty       = left == '0;
      sts.byte_valid  = byte_valid_ff;
      sts.bit_hit     = bit_hit;
   end

   // Next packet length and bit position
   always_comb begin
      len_in = len_ff;
      pos_in = pos_ff;
      if (cmd.clear) begin
         len_in = '0;
         pos_in = '0;
      end
      if (cmd.append) begin
         len_in = len_ff + 1'b1;
      end
      if (cmd.advance) begin
         pos_in = pos_ff + PW'(cnt_ff);
      end
      if (cmd.align) begin
         pos_in = (up_al > {1'b0, total}) ? total : up_al[PW-1:0];
      end
      if (cmd.unary_bit) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         pos_ff        <= '0;
         byte_valid_ff <= 1'b0;
         k_ff          <= '0;
      end else begin
         len_ff <= len_in;
         pos_ff <= pos_in;
         // Track the unary byte window
         if (cmd.unary_init) begin
            byte_valid_ff <= 1'b0;
         end else if (cmd.unary_load) begin
            byte_valid_ff <= 1'b1;
         end else if (cmd.unary_bit && pos_ff[2:0] == 3'd7) begin
            byte_valid_ff <= 1'b0;
         end
         // Advance the fetch counter
         if (cmd.gather_init) begin
            k_ff <= '0;
         end else if (cmd.gather_step) begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   // Store appended bytes, read one byte per cycle
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[len_ff[AW-1:0]] <= byte_ff;
      end
      rd_data_ff <= mem[raddr];
      rd_ok_ff   <= in_range;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         byte_ff <= req_byte_value;
         cnt_ff  <= req_bit_count;
         stop_ff <= req_stop_bit;
         max_ff  <= req_max_value;
      end
      // Shift fetched bytes in from the top, lowest byte ends at the bottom
      if (cmd.gather_step && k_ff != '0) begin
         buf_ff <= {(rd_ok_ff ? rd_data_ff : 8'h00), buf_ff[8*lbr_pkg::FETCH_BYTES-1:8]};
      end
      if (cmd.unary_init) begin
         ucnt_ff <= '0;
      end else if (cmd.unary_bit && !bit_hit) begin
         ucnt_ff <= ucnt_ff + 1'b1;
      end
      if (cmd.unary_load) begin
         cur_byte_ff <= rd_data_ff;
      end
      // Outcome of the operation
      if (cmd.set_ok) begin
         ok_ff  <= cmd.ok_value;
         val_ff <= '0;
      end else if (cmd.gather_end) begin
         ok_ff  <= 1'b1;
         val_ff <= field;
      end else if (cmd.unary_end) begin
         ok_ff  <= cmd.ok_value;
         val_ff <= 32'(ucnt_ff);
      end
      if (cmd.publish) begin
         cons_ff <= 16'(pos_ff);
         rem_ff  <= 16'(left);
      end
   end

   assign rsp_ok             = ok_ff;
   assign rsp_value          = val_ff;
   assign rsp_bits_consumed  = cons_ff;
   assign rsp_bits_remaining = rem_ff;

endmodule

### src/lbr_ctrl.sv
module lbr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  lbr_pkg::ctl_sts_type sts,
   output lbr_pkg::ctl_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXEC   = 7'b0000010,
      ST_GATHER = 7'b0000100,
      ST_GFIN   = 7'b0001000,
      ST_UCHK   = 7'b0010000,
      ST_ULOAD  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   // Sequence each operation
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.set_ok = 1'b1;
            state_in   = ST_DONE;
            case (sts.op)
               lbr_pkg::OP_CLEAR: begin
                  cmd.clear    = 1'b1;
                  cmd.ok_value = 1'b1;
               end
               lbr_pkg::OP_APPEND: begin
                  cmd.append   = !sts.full;
                  cmd.ok_value = !sts.full;
               end
               lbr_pkg::OP_READ: begin
                  if (sts.read_fits) begin
                     cmd.gather_init = 1'b1;
                     state_in        = ST_GATHER;
                  end
               end
               lbr_pkg::OP_PEEK: begin
                  if (sts.peek_fits) begin
                     cmd.gather_init = 1'b1;
                     state_in        = ST_GATHER;
                  end
               end
               lbr_pkg::OP_UNARY: begin
                  cmd.unary_init = 1'b1;
                  state_in       = ST_UCHK;
               end
               lbr_pkg::OP_SKIP: begin
                  cmd.advance  = sts.skip_fits;
                  cmd.ok_value = sts.skip_fits;
               end
               lbr_pkg::OP_ALIGN: begin
                  cmd.align    = 1'b1;
                  cmd.ok_value = 1'b1;
               end
               default: begin
                  cmd.ok_value = 1'b0;
               end
            endcase
         end
         ST_GATHER: begin
            cmd.gather_step = 1'b1;
            if (sts.gather_last) begin
               state_in = ST_GFIN;
            end
         end
         ST_GFIN: begin
            cmd.gather_end = 1'b1;
            cmd.advance    = sts.op == lbr_pkg::OP_READ;
            state_in       = ST_DONE;
         end
         ST_UCHK: begin
            if (sts.at_max) begin
               cmd.unary_end = 1'b1;
               cmd.ok_value  = 1'b1;
               state_in      = ST_DONE;
            end else if (sts.empty) begin
               cmd.unary_end = 1'b1;
               cmd.ok_value  = 1'b0;
               state_in      = ST_DONE;
            end else if (!sts.byte_valid) begin
               // The byte under the position is read this cycle
               state_in = ST_ULOAD;
            end else begin
               cmd.unary_bit = 1'b1;
               if (sts.bit_hit) begin
                  cmd.unary_end = 1'b1;
                  cmd.ok_value  = 1'b1;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_ULOAD: begin
            cmd.unary_load = 1'b1;
            state_in       = ST_UCHK;
         end
         ST_DONE: begin
            cmd.publish = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= state_ff == ST_DONE;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### src/lsb_first_bit_reader_top.sv
// LSB-first bit reader. Build a packet with clear and append, then read, peek,
// skip, count unary codes or align; bit k of the packet is bit k mod 8 of byte
// k div 8. A request transfers when start is high and busy is low; exactly one
// result follows, shown for one cycle with rsp_valid high, and it cannot be
// stalled, so the receiver must take it in that cycle. Clear, append, skip,
// align, unused codes and failed read or peek checks are done in the execute
// state and go straight to the result. A read or peek gathers its field byte
// by byte: the byte store has a single read port and the five bytes that can
// hold a field come out of it one per cycle, each in the cycle after its
// address. A unary code steps one bit a cycle while its byte is loaded, and
// loads each new byte through a check state that reads it and a load state
// that takes it. The next request may transfer in the cycle its predecessor's
// result is shown. The byte store needs no initialization after reset.
module lsb_first_bit_reader_top #(
   parameter int PACKET_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_byte_value,
   input  logic [15:0] req_bit_count,
   input  logic        req_stop_bit,
   input  logic [15:0] req_max_value,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [31:0] rsp_value,
   output logic [15:0] rsp_bits_consumed,
   output logic [15:0] rsp_bits_remaining
);

   lbr_pkg::ctl_cmd_type cmd;
   lbr_pkg::ctl_sts_type sts;

   // Sequence the operations
   lbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the packet, the position and the results
   lbr_datapath #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_operation      (req_operation),
      .req_byte_value     (req_byte_value),
      .req_bit_count      (req_bit_count),
      .req_stop_bit       (req_stop_bit),
      .req_max_value      (req_max_value),
      .rsp_ok             (rsp_ok),
      .rsp_value          (rsp_value),
      .rsp_bits_consumed  (rsp_bits_consumed),
      .rsp_bits_remaining (rsp_bits_remaining)
   );

endmodule

### src/lbr_checker.sv
module lbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ok,
   input logic [15:0] rsp_bits_consumed,
   input logic [15:0] rsp_bits_remaining
);

   // No result in the cycle right after a transfer
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result shown right after a request transfer");

   // A result shows up as the block goes idle
   a_rsp_on_idle: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("block went idle without a result");

   // A result is not repeated back to back
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result repeated");

   // Position plus remaining bits is the packet size, a whole number of bytes
   a_byte_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_bits_consumed[2:0] + rsp_bits_remaining[2:0]) & 3'd7) == 3'd0)
      else $error("packet size not a whole number of bytes");

   // Clear answers with an ok result and an empty packet
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == lbr_pkg::OP_CLEAR) |-> ##3
      (rsp_valid && rsp_ok && rsp_bits_consumed == 16'd0 && rsp_bits_remaining == 16'd0))
      else $error("clear gave a wrong result");

endmodule

bind lsb_first_bit_reader_top lbr_checker u_lbr_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_operation      (req_operation),
   .rsp_valid          (rsp_valid),
   .rsp_ok             (rsp_ok),
   .rsp_bits_consumed  (rsp_bits_consumed),
   .rsp_bits_remaining (rsp_bits_remaining)
);
